// File: rtl/fixed_point_to_seven_segment_core_assert.svh
// Assertion macros shared by the formatter's RTL files.
`ifndef FIXED_POINT_TO_SEVEN_SEGMENT_CORE_ASSERT_SVH
`define FIXED_POINT_TO_SEVEN_SEGMENT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define FPSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FPSS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define FPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/fpss_pkg.sv
// Shared types, constants and tables of the seven-segment number formatter.
package fpss_pkg;

  localparam int unsigned QueueDepthDefault = 2;

  localparam logic [7:0] SegBlank = 8'h00;
  localparam logic [7:0] SegMinus = 8'h40;
  localparam logic [7:0] SegPoint = 8'h80;

  localparam logic [13:0] MaxShown = 14'd9999;

  // Reciprocals for dividing values below 10000 by 10, 100 and 1000.
  localparam logic [15:0] Recip10   = 16'd52429;  // shift 19
  localparam logic [12:0] Recip100  = 13'd5243;   // shift 19
  localparam logic [13:0] Recip1000 = 14'd8389;   // shift 23

  typedef struct packed {
    logic [3:0][3:0] digits;    // index 0 is the leftmost digit
    logic [1:0]      unit_pos;
    logic            neg;
  } fmt_t;

  function automatic logic [7:0] seg_font(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = SegBlank;
    endcase
    return seg;
  endfunction

  function automatic logic [9:0] pow_ten(input logic [1:0] places);
    logic [9:0] p;
    unique case (places)
      2'd0: p = 10'd1;
      2'd1: p = 10'd10;
      2'd2: p = 10'd100;
      2'd3: p = 10'd1000;
      default: p = 10'd1;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/fpss_front.sv
// Front pipeline: magnitude, scaling, rounding, saturation and digit split.
module fpss_front import fpss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] value_i,
  input  logic        [2:0]  decimal_places_i,
  input  logic               q_ready_i,
  output logic               push_o,
  output fmt_t               push_data_o
);

  logic        v1_q, v2_q, v3_q, v4_q;
  logic        en1, en2, en3, en4;

  logic [31:0] mag_q;
  logic [1:0]  places_q;
  logic        neg1_q, neg2_q, neg3_q, neg4_q;
  logic [1:0]  unit2_q, unit3_q, unit4_q;
  logic [41:0] prod_q;
  logic [13:0] num3_q, num4_q;
  logic [9:0]  q10_q;
  logic [6:0]  q100_q;
  logic [3:0]  q1000_q;

  logic [31:0] mag_d;
  logic [1:0]  places_d;
  logic [42:0] rsum;
  logic [26:0] rnd;
  logic [13:0] num_d;
  logic [29:0] p10;
  logic [26:0] p100;
  logic [27:0] p1000;
  logic [7:0]  t1;
  logic [10:0] t2;
  logic [13:0] t3;

  // Each stage moves when it is empty or the stage after it moves.
  assign en4 = !v4_q || q_ready_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_comb begin
    mag_d    = value_i[31] ? (32'd0 - 32'(value_i)) : 32'(value_i);
    places_d = (decimal_places_i > 3'd3) ? 2'd3 : decimal_places_i[1:0];
  end

  // Round half up at the binary point, then clamp to four digits.
  always_comb begin
    rsum  = {1'b0, prod_q} + 43'h8000;
    rnd   = rsum[42:16];
    num_d = (rnd > 27'(MaxShown)) ? MaxShown : rnd[13:0];
  end

  always_comb begin
    p10   = 30'(num3_q) * 30'(Recip10);
    p100  = 27'(num3_q) * 27'(Recip100);
    p1000 = 28'(num3_q) * 28'(Recip1000);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      mag_q    <= mag_d;
      places_q <= places_d;
      neg1_q   <= value_i[31];
    end
    if (en2) begin
      prod_q  <= 42'(mag_q) * 42'(pow_ten(places_q));
      unit2_q <= 2'd3 - places_q;
      neg2_q  <= neg1_q;
    end
    if (en3) begin
      num3_q  <= num_d;
      unit3_q <= unit2_q;
      neg3_q  <= neg2_q;
    end
    if (en4) begin
      q10_q   <= p10[28:19];
      q100_q  <= p100[25:19];
      q1000_q <= p1000[26:23];
      num4_q  <= num3_q;
      unit4_q <= unit3_q;
      neg4_q  <= neg3_q;
    end
  end

  always_comb begin
    t1 = 8'(q100_q) - 8'(q1000_q) * 8'd10;
    t2 = 11'(q10_q) - 11'(q100_q) * 11'd10;
    t3 = num4_q - 14'(q10_q) * 14'd10;
    push_data_o.digits[0] = q1000_q;
    push_data_o.digits[1] = t1[3:0];
    push_data_o.digits[2] = t2[3:0];
    push_data_o.digits[3] = t3[3:0];
    push_data_o.unit_pos  = unit4_q;
    push_data_o.neg       = neg4_q;
  end

  assign push_o = v4_q && q_ready_i;

endmodule

// File: rtl/fpss_queue.sv
// Small FIFO of formatted numbers between the front and the back.
module fpss_queue import fpss_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  fmt_t push_data_i,
  output logic ready_o,
  input  logic pop_i,
  output logic head_valid_o,
  output fmt_t head_data_o
);

`include "fixed_point_to_seven_segment_core_assert.svh"

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  fmt_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign ready_o      = (count_q != CntW'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `FPSS_ASSERT_IMPLIES(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Depth), "queue count overflow")
  `FPSS_ASSERT_IMPLIES(a_no_push_full, clk_i, rst_ni, push_i, ready_o, "push into full queue")
  `FPSS_ASSERT_IMPLIES(a_no_pop_empty, clk_i, rst_ni, pop_i, head_valid_o, "pop from empty queue")

endmodule

// File: rtl/fpss_back.sv
// Back end: blanking, sign and decimal point placement and the four digit writes of each item.
module fpss_back import fpss_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  fmt_t       head_data_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] grid_address_o,
  output logic [7:0] segments_o,
  output logic       last_digit_o
);

`include "fixed_point_to_seven_segment_core_assert.svh"

  logic [1:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  logic [2:0] grid_q;
  logic [7:0] seg_q, seg_d;
  logic       last_q;
  logic       out_load;
  logic [1:0] first_pos;

  assign out_load = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o    = out_load && (pos_q == 2'd3);

  // First position that shows: a nonzero digit or the units digit.
  always_comb begin
    priority if (head_data_i.digits[0] != 4'd0 || head_data_i.unit_pos == 2'd0) begin
      first_pos = 2'd0;
    end else if (head_data_i.digits[1] != 4'd0 || head_data_i.unit_pos == 2'd1) begin
      first_pos = 2'd1;
    end else if (head_data_i.digits[2] != 4'd0 || head_data_i.unit_pos == 2'd2) begin
      first_pos = 2'd2;
    end else begin
      first_pos = 2'd3;
    end
  end

  always_comb begin
    if (pos_q < first_pos) begin
      seg_d = (head_data_i.neg && (pos_q == first_pos - 2'd1)) ? SegMinus : SegBlank;
    end else begin
      seg_d = seg_font(head_data_i.digits[pos_q]);
      if (pos_q == head_data_i.unit_pos) begin
        seg_d = seg_d | SegPoint;
      end
    end
  end

  always_comb begin
    pos_d       = out_load ? pos_q + 2'd1 : pos_q;
    out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      grid_q <= {pos_q, 1'b0};
      seg_q  <= seg_d;
      last_q <= (pos_q == 2'd3);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign grid_address_o = grid_q;
  assign segments_o     = seg_q;
  assign last_digit_o   = last_q;

  `FPSS_ASSERT_IMPLIES(a_mid_item_held, clk_i, rst_ni, pos_q != 2'd0, head_valid_i, "item left queue before its last write")
  `FPSS_ASSERT_IMPLIES(a_last_addr, clk_i, rst_ni, out_valid_q && last_q, grid_q == 3'd6, "last write not at rightmost address")
  `FPSS_ASSERT_NEXT(a_writes_contiguous, clk_i, rst_ni, out_valid_q && out_ready_i && !last_q, out_valid_q, "gap inside one item's writes")

endmodule

// File: rtl/fixed_point_to_seven_segment_core.sv
// An item passes the front stages, the queue and the output register before its first digit write is shown.
// The back end gives one digit write per cycle while out_ready_i allows, and pops an item only with its last write.
// The front pipeline takes an item in every cycle until the queue between the halves and its own stages fill.
// Reset is asynchronous and active low; it empties the pipeline, queue and output register.
// Top level of the four-digit seven-segment number formatter.
module fixed_point_to_seven_segment_core import fpss_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] value_i,
  input  logic        [2:0]  decimal_places_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic        [2:0]  grid_address_o,
  output logic        [7:0]  segments_o,
  output logic               last_digit_o
);

  logic push, q_ready, pop, head_valid;
  fmt_t push_data, head_data;

  fpss_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .value_i,
    .decimal_places_i,
    .q_ready_i   (q_ready),
    .push_o      (push),
    .push_data_o (push_data)
  );

  fpss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_data_i  (push_data),
    .ready_o      (q_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  fpss_back u_back (
    .clk_i,
    .rst_ni,
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .grid_address_o,
    .segments_o,
    .last_digit_o
  );

endmodule
